// File: hdl/imu_sfd_pkg.sv
// ----------------------------------------------------------------------------
// imu_sfd_pkg
// shared constants and types of the imu serial frame decoder
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

  // frame layout
  localparam logic [7:0] FRAME_HEADER = 8'h55;
  localparam logic [7:0] TYPE_ACCEL   = 8'h51;
  localparam logic [7:0] TYPE_GYRO    = 8'h52;
  localparam logic [7:0] TYPE_ANGLE   = 8'h53;
  localparam logic [3:0] POS_CHECKSUM_PREV = 4'd9;  // position before checksum byte
  localparam logic [3:0] POS_PAYLOAD_FIRST = 4'd1;  // position before first payload byte

  // result kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // widths
  localparam int AXIS_W  = 23;
  localparam int WORD_W  = 16;
  localparam int NUM_WORDS = 4;

  // default depth of the frame queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one decoded frame waiting for scaling
  typedef struct packed {
    logic [1:0]                         kind;
    logic [NUM_WORDS-1:0][WORD_W-1:0]   words;
  } frame_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// File: hdl/imu_sfd_if.sv
// ----------------------------------------------------------------------------
// imu_sfd_if
// byte and result channels of the imu serial frame decoder
// ----------------------------------------------------------------------------
interface imu_sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

interface imu_sfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic signed [22:0] axis_x;
  logic signed [22:0] axis_y;
  logic signed [22:0] axis_z;
  logic signed [15:0] temperature;

  modport source (output valid, output frame_kind, output axis_x, output axis_y,
                  output axis_z, output temperature, input ready);
  modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                  input axis_z, input temperature, output ready);
endinterface

// File: hdl/imu_sfd_front.sv
// ----------------------------------------------------------------------------
// imu_sfd_front
// header hunt, frame assembly, checksum and type classification
// ----------------------------------------------------------------------------
module imu_sfd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  imu_sfd_byte_if.sink                in_ch,
  input  imu_sfd_pkg::queue_status_t  q_stat,
  output logic                        push,
  output imu_sfd_pkg::frame_entry_t   push_entry
);
  import imu_sfd_pkg::*;

  logic        in_frame_r, in_frame_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r;
  logic [63:0] payload_r;

  logic        accept;
  logic        last_byte;
  logic        known_type;
  logic [1:0]  kind;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_byte   = in_frame_r && (pos_r == POS_CHECKSUM_PREV);

  always_comb begin
    known_type = 1'b1;
    case (type_r)
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_GYRO:  kind = KIND_GYRO;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default: begin
        kind       = KIND_ACCEL;
        known_type = 1'b0;
      end
    endcase
  end

  assign push             = accept && last_byte && (sum_r == in_ch.rx_data) && known_type;
  assign push_entry.kind  = kind;
  assign push_entry.words = payload_r;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_ch.rx_data == FRAME_HEADER) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = 4'd0;
          sum_nxt      = FRAME_HEADER;
        end
      end else if (last_byte) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = 4'd0;
        sum_nxt      = 8'd0;
      end else begin
        pos_nxt = pos_r + 4'd1;
        sum_nxt = sum_r + in_ch.rx_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= 4'd0;
      sum_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
    end
  end

  // type byte and payload shift line, little-endian bytes land in order
  always_ff @(posedge clk) begin
    if (accept && in_frame_r && !last_byte) begin
      if (pos_r == 4'd0) begin
        type_r <= in_ch.rx_data;
      end else if (pos_r >= POS_PAYLOAD_FIRST) begin
        payload_r <= {in_ch.rx_data, payload_r[63:8]};
      end
    end
  end

endmodule

// File: hdl/imu_sfd_queue.sv
// ----------------------------------------------------------------------------
// imu_sfd_queue
// short frame queue between front and back
// ----------------------------------------------------------------------------
module imu_sfd_queue #(
  parameter int DEPTH = imu_sfd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  imu_sfd_pkg::frame_entry_t   push_entry,
  input  logic                        pop,
  output imu_sfd_pkg::frame_entry_t   head_entry,
  output imu_sfd_pkg::queue_status_t  q_stat
);
  import imu_sfd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_entry_t     mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full      = (count_r == FULL_CNT);
  assign q_stat.not_empty = (count_r != '0);
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign head_entry       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hdl/imu_sfd_back.sv
// ----------------------------------------------------------------------------
// imu_sfd_back
// per-axis scaling and registered result stage
// ----------------------------------------------------------------------------
module imu_sfd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imu_sfd_pkg::frame_entry_t   head_entry,
  input  imu_sfd_pkg::queue_status_t  q_stat,
  output logic                        pop,
  imu_sfd_result_if.source            out_ch
);
  import imu_sfd_pkg::*;

  function automatic logic signed [AXIS_W-1:0] scale_axis(
    input logic [1:0]               k,
    input logic signed [WORD_W-1:0] raw
  );
    logic signed [AXIS_W-1:0]   prod125;
    logic signed [AXIS_W-2:0]   prod45;
    logic signed [AXIS_W-1:0]   res;
    prod125 = AXIS_W'(raw) * $signed(AXIS_W'(125));
    prod45  = (AXIS_W-1)'(raw) * $signed((AXIS_W-1)'(45));
    case (k)
      KIND_ACCEL: res = AXIS_W'(raw);
      KIND_GYRO:  res = prod125;
      KIND_ANGLE: res = AXIS_W'(prod45 >>> 2);  // floor of raw*45/4
      default:    res = '0;
    endcase
    return res;
  endfunction

  logic                     out_valid_r;
  logic [1:0]               kind_r;
  logic signed [AXIS_W-1:0] axis_r [3];
  logic signed [WORD_W-1:0] temp_r;

  assign pop = q_stat.not_empty && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head_entry.kind;
      for (int i = 0; i < 3; i++) begin
        axis_r[i] <= scale_axis(head_entry.kind, $signed(head_entry.words[i]));
      end
      temp_r <= (head_entry.kind == KIND_ACCEL) ? $signed(head_entry.words[3]) : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_kind  = kind_r;
  assign out_ch.axis_x      = axis_r[0];
  assign out_ch.axis_y      = axis_r[1];
  assign out_ch.axis_z      = axis_r[2];
  assign out_ch.temperature = temp_r;

endmodule

// File: hdl/imu_serial_frame_decoder_top.sv
// a result passes the frame queue, then the output register, after its checksum byte
// throughput: one byte per cycle unless stalled; at most one result per 11 bytes
// in_ch.ready drops only while the frame queue is full (output stalled)
// reset: synchronous active-low rst_n; hunting for header, queue and output empty
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_top
// decodes 11-byte imu serial frames into scaled acceleration, rate or angle
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top #(
  parameter int QUEUE_DEPTH = imu_sfd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  imu_sfd_byte_if.sink      in_ch,
  imu_sfd_result_if.source  out_ch
);
  import imu_sfd_pkg::*;

  // front to queue
  logic          push;
  frame_entry_t  push_entry;

  // queue to back
  logic          pop;
  frame_entry_t  head_entry;
  queue_status_t q_stat;

  // front: hunts for the header, keeps the running sum, and on the checksum
  // byte of a good frame with a known type pushes kind plus raw words
  imu_sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue so the byte side keeps running while a result waits
  imu_sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  // back: constant multiply per axis into the output register, one transfer
  // per cycle while the queue holds frames and the sink keeps ready high
  imu_sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// File: verif/tb_imu_serial_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_imu_serial_frame_decoder_top
// self-checking bench: serial byte stream in, decoded and scaled frames out
//
// The bench feeds the decoder a byte stream. A short directed part comes first:
// bytes seen while hunting, extreme words for every frame type, a bad checksum,
// an unknown type and a header byte inside a frame. The random part is mostly
// well-formed frames with random content, mixed with bad checksums, unknown
// types, noise and cut-off frames. A scoreboard class predicts each decoded
// frame from the accepted bytes and compares every result field by field. The
// sender works in bursts with gaps, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_imu_serial_frame_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imu_sfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned BYTE_TARGET = 1450;
  localparam int unsigned FRAME_LEN   = 11;

  // one decoded frame as it leaves the block
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [22:0] x;
    logic signed [22:0] y;
    logic signed [22:0] z;
    logic signed [15:0] temp;
  } imu_result_t;

  // --------------------------------------------------------------------------
  // frame scoreboard: tracks the decoder state from accepted bytes and keeps
  // the decoded frames still owed by the block
  // --------------------------------------------------------------------------
  class imu_frame_scoreboard;
    bit          in_frame;
    bit [3:0]    byte_pos;
    bit [7:0]    frame_sum;
    bit [7:0]    frame_type;
    bit [7:0]    payload [8];
    imu_result_t owed_frames [$];
    int unsigned error_count;

    function new();
      in_frame    = 1'b0;
      byte_pos    = '0;
      frame_sum   = '0;
      frame_type  = '0;
      foreach (payload[i]) payload[i] = '0;
      error_count = 0;
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    // little-endian signed word k of the payload
    function int raw_word(int k);
      logic signed [15:0] w;
      w = {payload[2*k+1], payload[2*k]};
      return int'(w);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      imu_result_t r;
      int          scaled [3];
      if (!in_frame) begin
        // hunting: everything but the header is dropped
        if (b == FRAME_HEADER) begin
          in_frame  = 1'b1;
          byte_pos  = '0;
          frame_sum = FRAME_HEADER;
        end
        return;
      end
      byte_pos = byte_pos + 4'd1;
      if (byte_pos < 4'(FRAME_LEN - 1)) begin
        // no resync inside a frame, a header value is plain data here
        if (byte_pos == 4'd1) begin
          frame_type = b;
        end else begin
          payload[byte_pos - 4'd2] = b;
        end
        frame_sum = frame_sum + b;
        return;
      end
      // checksum byte closes the frame either way
      in_frame = 1'b0;
      byte_pos = '0;
      if (frame_sum != b) begin
        frame_sum = '0;
        return;
      end
      frame_sum = '0;
      r.temp = '0;
      case (frame_type)
        TYPE_ACCEL: begin
          r.kind = KIND_ACCEL;
          for (int i = 0; i < 3; i++) scaled[i] = raw_word(i);
          r.temp = 16'(raw_word(3));
        end
        TYPE_GYRO: begin
          r.kind = KIND_GYRO;
          for (int i = 0; i < 3; i++) scaled[i] = raw_word(i) * 125;
        end
        TYPE_ANGLE: begin
          // floor(raw * 45 / 4)
          r.kind = KIND_ANGLE;
          for (int i = 0; i < 3; i++) scaled[i] = (raw_word(i) * 45) >>> 2;
        end
        default: return;
      endcase
      r.x = 23'(scaled[0]);
      r.y = 23'(scaled[1]);
      r.z = 23'(scaled[2]);
      owed_frames.push_back(r);
    endfunction

    function void check_decoded(imu_result_t got);
      imu_result_t want;
      if (owed_frames.size() == 0) begin
        $error("decoded frame with none owed: frame_kind %0d", got.kind);
        error_count++;
        return;
      end
      want = owed_frames.pop_front();
      if (got.kind !== want.kind) begin
        $error("frame_kind expected %0d got %0d", want.kind, got.kind);
        error_count++;
      end
      if (got.x !== want.x) begin
        $error("axis_x expected %0d got %0d", want.x, got.x);
        error_count++;
      end
      if (got.y !== want.y) begin
        $error("axis_y expected %0d got %0d", want.y, got.y);
        error_count++;
      end
      if (got.z !== want.z) begin
        $error("axis_z expected %0d got %0d", want.z, got.z);
        error_count++;
      end
      if (got.temp !== want.temp) begin
        $error("temperature expected %0d got %0d", want.temp, got.temp);
        error_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic result_ready = 1'b0;

  always #2 clk = ~clk;

  imu_sfd_byte_if   in_if ();
  imu_sfd_result_if out_if ();

  assign out_if.ready = result_ready;

  imu_serial_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  imu_frame_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_count = 0;

  // --------------------------------------------------------------------------
  // monitors: transfers are sampled at the rising edge, before the block's
  // own updates land
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    imu_result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_rx_byte(in_if.rx_data);
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.frame_kind;
        got.x    = out_if.axis_x;
        got.y    = out_if.axis_y;
        got.z    = out_if.axis_z;
        got.temp = out_if.temperature;
        sb.check_decoded(got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure: a new stall mode after each run of random length
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_count <= $urandom_range(16, 80);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0:       result_ready <= 1'b1;                         // never stalls
      1:       result_ready <= 1'($urandom_range(0, 1));     // coin toss
      2:       result_ready <= ($urandom_range(0, 7) != 0);  // rare stalls
      default: result_ready <= (stall_count[3:0] < 4'd3);    // long stalls
    endcase
  end

  // --------------------------------------------------------------------------
  // sender tasks, all called at a falling edge and returning at one
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    in_if.valid   <= 1'b1;
    in_if.rx_data <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic hold_off(input int unsigned n);
    if (n != 0) begin
      in_if.valid   <= 1'b0;
      in_if.rx_data <= 8'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  // bursts of random length; every third stretch of 200 bytes has no gaps
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ((bytes_sent / 200) % 3 != 1) hold_off($urandom_range(0, 6));
    end
    burst_left--;
    push_byte(b);
  endtask

  // sender pause until every owed frame has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [3:0][15:0] w,
                            input bit bad_sum);
    logic [7:0] fb [11];
    logic [7:0] s;
    fb[0] = FRAME_HEADER;
    fb[1] = ftype;
    for (int k = 0; k < 4; k++) begin
      fb[2 + 2*k] = w[k][7:0];
      fb[3 + 2*k] = w[k][15:8];
    end
    s = '0;
    for (int i = 0; i < 10; i++) s = s + fb[i];
    if (bad_sum) s = s ^ 8'(1 << $urandom_range(0, 7));
    fb[10] = s;
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // words lean toward the ends of the range and toward -1, 0 and 1
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0][15:0] pick_words();
    logic [3:0][15:0] w;
    for (int k = 0; k < 4; k++) w[k] = pick_word();
    return w;
  endfunction

  function automatic logic [7:0] pick_known_type();
    case ($urandom_range(0, 2))
      0:       return TYPE_ACCEL;
      1:       return TYPE_GYRO;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned n;
    in_if.valid   = 1'b0;
    in_if.rx_data = '0;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes while hunting are dropped
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'haa);
    // acceleration at both ends, coldest temperature
    send_frame(TYPE_ACCEL, {16'h8000, 16'h0000, 16'h8000, 16'h7fff}, 1'b0);
    // angular rate at both ends, fourth word ignored
    send_frame(TYPE_GYRO, {16'h1234, 16'hffff, 16'h7fff, 16'h8000}, 1'b0);
    // angle: -1 must round toward minus infinity
    send_frame(TYPE_ANGLE, {16'h7fff, 16'hffff, 16'h7fff, 16'h8000}, 1'b0);
    // checksum mismatch drops the frame
    send_frame(TYPE_ACCEL, {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b1);
    // unknown type with a good checksum drops the frame
    send_frame(8'h54, {16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1'b0);
    // header value inside a frame is plain data; hottest temperature
    send_frame(TYPE_ACCEL, {16'h7fff, 16'h5555, 16'h0055, 16'h5500}, 1'b0);
    wait_drained();

    // random part
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_known_type(), pick_words(), 1'b0);
      end else if (pick < 77) begin
        send_frame(8'($urandom), pick_words(), 1'b0);
      end else if (pick < 85) begin
        send_frame(pick_known_type(), pick_words(), 1'b1);
      end else if (pick < 93) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 99) begin
        // cut-off frame: the next frame's bytes get swallowed by it
        send_byte(FRAME_HEADER);
        n = $urandom_range(0, 9);
        repeat (n) send_byte(8'($urandom));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d decoded frames never came out", sb.pending());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
